/* rtl/mmbc_pkg.sv */
package mmbc_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [0:0] REG_MODE = 1'b0;

  localparam logic [1:0] MODE_CRC32   = 2'd0;
  localparam logic [1:0] MODE_ADLER32 = 2'd1;
  localparam logic [1:0] MODE_BSD     = 2'd2;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] ADLER_LOW_INIT  = 16'd1;
  localparam logic [15:0] ADLER_HIGH_INIT = 16'd0;
  localparam logic [15:0] BSD_INIT        = 16'd0;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_byte;
  } mmbc_item_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = CRC_POLY ^ (v >> 1);
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic [15:0] mod_step(input logic [16:0] v);
    logic [16:0] r;
    r = (v >= ADLER_MOD) ? (v - ADLER_MOD) : v;
    return r[15:0];
  endfunction

endpackage

/* rtl/mmbc_if.sv */
interface mmbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mmbc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum_value;

  modport source (output valid, output checksum_value, input ready);
  modport sink   (input valid, input checksum_value, output ready);
endinterface

/* rtl/mmbc_cfg_regs.sv */
module mmbc_cfg_regs
  import mmbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [1:0]        mode
);

  logic [1:0] mode_r;
  logic       hit;

  assign hit        = (cfg_paddr[CFG_AW-1:2] == REG_MODE);
  assign cfg_pready = 1'b1;
  assign mode       = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CRC32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (hit) begin
      cfg_prdata = {{(CFG_DW-2){1'b0}}, mode_r};
    end
  end

endmodule

/* rtl/mmbc_in_stage.sv */
module mmbc_in_stage
  import mmbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mmbc_in_if.sink    in_ch,
  input  logic       advance,
  output mmbc_item_t item
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       load;

  assign in_ch.ready = rst_n && (!valid_r || advance);
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_ch.data_byte;
      last_r <= in_ch.last_byte;
    end
  end

  assign item = '{valid: valid_r, data_byte: data_r, last_byte: last_r};

endmodule

/* rtl/mmbc_sum_core.sv */
module mmbc_sum_core
  import mmbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mmbc_item_t item,
  input  logic [1:0] mode,
  output logic       advance,
  mmbc_out_if.source out_ch
);

  logic [31:0] crc_r, crc_nxt;
  logic [15:0] alow_r, alow_nxt;
  logic [15:0] ahigh_r, ahigh_nxt;
  logic [15:0] bsd_r, bsd_nxt;
  logic        out_valid_r;
  logic [31:0] out_value_r, out_value_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = item.valid && (!item.last_byte || out_free);

  always_comb begin
    crc_nxt   = crc_byte(crc_r, item.data_byte);
    alow_nxt  = mod_step({1'b0, alow_r} + {9'd0, item.data_byte});
    ahigh_nxt = mod_step({1'b0, ahigh_r} + {1'b0, alow_nxt});
    bsd_nxt   = {bsd_r[0], bsd_r[15:1]} + {8'd0, item.data_byte};
    case (mode)
      MODE_CRC32:   out_value_nxt = crc_nxt ^ CRC_INIT;
      MODE_ADLER32: out_value_nxt = {ahigh_nxt, alow_nxt};
      MODE_BSD:     out_value_nxt = {16'd0, bsd_nxt};
      default:      out_value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      alow_r  <= ADLER_LOW_INIT;
      ahigh_r <= ADLER_HIGH_INIT;
      bsd_r   <= BSD_INIT;
    end else if (advance) begin
      if (item.last_byte) begin
        crc_r   <= CRC_INIT;
        alow_r  <= ADLER_LOW_INIT;
        ahigh_r <= ADLER_HIGH_INIT;
        bsd_r   <= BSD_INIT;
      end else begin
        crc_r   <= crc_nxt;
        alow_r  <= alow_nxt;
        ahigh_r <= ahigh_nxt;
        bsd_r   <= bsd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && item.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.checksum_value = out_value_r;

endmodule

/* rtl/multi_mode_byte_checksum_core.sv */
// Multi-mode byte checksum: CRC-32, Adler-32 or BSD 16-bit sum over a byte stream.
//
// in_ch carries one message byte per request with a last flag; a request is
// taken when valid and ready are both high. out_ch carries one checksum per
// message, after the byte flagged last. The checksum type comes from the mode
// register at APB byte address 0 (0 CRC-32, 1 Adler-32, 2 BSD sum, 3 zero);
// change it only while no message is in flight.
//
// Throughput is one byte per cycle while out_ch is free: a byte sits in the input
// register while the sum update and result select run combinationally into
// the result register. With out_ch free, out_ch.valid rises once the last byte
// has passed through the input register and then the result register. The three
// sums run side by side and restart after each last byte.
//
// While out_ch is stalled the result holds; non-last bytes keep flowing, and a
// second last byte waits in the input register, which then drops in_ch.ready.
// Reset (rst_n low, synchronous) empties both registers, restarts all sums
// and sets the mode to CRC-32; in_ch.ready stays low during reset.
module multi_mode_byte_checksum_core
  import mmbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mmbc_in_if.sink           in_ch,
  mmbc_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [1:0] mode;
  logic       advance;
  mmbc_item_t item;

  mmbc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode        (mode)
  );

  mmbc_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .item    (item)
  );

  mmbc_sum_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .mode    (mode),
    .advance (advance),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/mmbc_checker.sv */
module mmbc_checker
  import mmbc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last_byte,
  input logic              out_valid,
  input logic              out_ready,
  input logic [31:0]       out_checksum_value,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [CFG_DW-1:0] cfg_pwdata,
  input logic [CFG_DW-1:0] cfg_prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_checksum_value))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte, 2))
    else $error("result without a last byte two cycles earlier");

  a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[CFG_AW-1:2] == REG_MODE)
    |=> (cfg_paddr[CFG_AW-1:2] != REG_MODE) || (cfg_prdata[1:0] == $past(cfg_pwdata[1:0])))
    else $error("mode readback mismatch");

endmodule

bind multi_mode_byte_checksum_core mmbc_checker u_mmbc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_last_byte       (in_ch.last_byte),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_checksum_value (out_ch.checksum_value),
  .cfg_psel           (cfg_psel),
  .cfg_penable        (cfg_penable),
  .cfg_pwrite         (cfg_pwrite),
  .cfg_paddr          (cfg_paddr),
  .cfg_pwdata         (cfg_pwdata),
  .cfg_prdata         (cfg_prdata)
);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import mmbc_pkg::*;

  localparam logic [1:0]  MODE_ZERO      = 2'd3;
  localparam logic [31:0] CRC32_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC32_SEED     = 32'hFFFF_FFFF;
  localparam logic [16:0] ADLER_BASE     = 17'd65521;
  localparam int          TARGET_BYTES   = 1750;
  localparam int          DRAIN_CYCLES   = 4;
  localparam int          WATCHDOG_LIMIT = 2000;

  class checksum_scoreboard;
    logic [1:0]  mode;
    logic [31:0] crc;
    logic [15:0] adler_lo;
    logic [15:0] adler_hi;
    logic [15:0] bsd_sum;
    logic [31:0] expected_checksums[$];

    function new();
      mode = MODE_CRC32;
      restart();
    endfunction

    function void restart();
      crc      = CRC32_SEED;
      adler_lo = 16'd1;
      adler_hi = 16'd0;
      bsd_sum  = 16'd0;
    endfunction

    function int pending();
      return expected_checksums.size();
    endfunction

    function void note_request(input logic [7:0] b, input logic is_last);
      logic [16:0] acc;
      logic [31:0] sum;
      crc = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC32_POLY) : (crc >> 1);
      end
      acc = {1'b0, adler_lo} + {9'd0, b};
      if (acc >= ADLER_BASE) begin
        acc = acc - ADLER_BASE;
      end
      adler_lo = acc[15:0];
      acc = {1'b0, adler_hi} + {1'b0, adler_lo};
      if (acc >= ADLER_BASE) begin
        acc = acc - ADLER_BASE;
      end
      adler_hi = acc[15:0];
      bsd_sum = {bsd_sum[0], bsd_sum[15:1]} + {8'd0, b};
      if (!is_last) begin
        return;
      end
      case (mode)
        MODE_CRC32:   sum = crc ^ CRC32_SEED;
        MODE_ADLER32: sum = {adler_hi, adler_lo};
        MODE_BSD:     sum = {16'd0, bsd_sum};
        default:      sum = 32'd0;
      endcase
      expected_checksums.push_back(sum);
      restart();
    endfunction

    function string check_result(input logic [31:0] got);
      logic [31:0] want;
      if (expected_checksums.size() == 0) begin
        return $sformatf("checksum %08h with no message pending", got);
      end
      want = expected_checksums.pop_front();
      if (got !== want) begin
        return $sformatf("checksum_value %08h, expected %08h (mode %0d)", got, want, mode);
      end
      return "";
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  mmbc_in_if  in_ch();
  mmbc_out_if out_ch();

  multi_mode_byte_checksum_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  checksum_scoreboard sb = new();
  int    mismatches  = 0;
  int    bytes_sent  = 0;
  int    idle_cycles = 0;
  logic  steady      = 1'b0;
  string verdict_msg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_request(in_ch.data_byte, in_ch.last_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        verdict_msg = sb.check_result(out_ch.checksum_value);
        if (verdict_msg.len() != 0) begin
          report_mismatch(verdict_msg);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (!steady && $urandom_range(0, 99) < 36) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk) in_ch.valid <= 1'b0;
  endtask

  // heavy messages lean on 0xFF to push both Adler sums past the modulus
  task automatic send_bytes(input int len, input bit heavy, input bit close);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (heavy && $urandom_range(0, 9) != 0) ? 8'hFF : 8'($urandom);
      send_byte(b, close && (i == len - 1));
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_drained();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_MODE, 2'b00};
    cfg_pwdata  <= {30'($urandom), m};
    @(negedge clk) cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.mode = m;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    int         phase;
    int         len;
    logic [1:0] m;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    write_mode(MODE_CRC32);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    end_burst();
    write_mode(MODE_ADLER32);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    end_burst();
    write_mode(MODE_BSD);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    end_burst();
    write_mode(MODE_ZERO);
    send_byte(8'h80, 1'b1);
    // mode switch in the middle of a message
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    end_burst();
    write_mode(MODE_CRC32);
    send_byte(8'h56, 1'b1);
    end_burst();

    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      steady = (phase == 5);
      m = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
      write_mode(m);
      repeat ($urandom_range(4, 20)) begin
        if ($urandom_range(0, 39) == 0) begin
          send_bytes($urandom_range(260, 300), 1'b1, 1'b1);
        end else begin
          len = $urandom_range(1, 12);
          send_bytes(len, $urandom_range(0, 3) == 0, 1'b1);
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        send_bytes($urandom_range(1, 5), 1'b0, 1'b0);
      end
      end_burst();
      phase++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
